// ===== sv/cpsdp_pkg.sv =====
// shared types, codes and constants of the count-prefixed signed decimal parser
package cpsdp_pkg;

    localparam int unsigned MAX_DIGITS_DEF  = 20;
    localparam int unsigned DEPTH_LIMIT_DEF = 30;
    localparam int unsigned VALUE_BITS_DEF  = 64;

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOD  = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PROTO    = 3'd1,
        ST_EOD      = 3'd2,
        ST_NONDIGIT = 3'd3,
        ST_LEADZERO = 3'd4,
        ST_EOF      = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic [1:0] kind;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic        negative;
        logic [63:0] value;
    } out_t;

    // character of the decimal text of 2^value_bits-1, k places from the right
    function automatic logic [7:0] max_digit_char(input int unsigned value_bits,
                                                  input int unsigned k);
        logic [63:0] m;
        m = {64{1'b1}} >> (64 - value_bits);
        for (int unsigned i = 0; i < k; i++) begin
            m = m / 10;
        end
        return CH_ZERO + 8'(m % 10);
    endfunction

endpackage

// ===== sv/cpsdp_core.sv =====
// decode state and single-pass step logic, one beat per cycle while take is high
module cpsdp_core #(
    parameter int unsigned MAX_DIGITS  = cpsdp_pkg::MAX_DIGITS_DEF,
    parameter int unsigned DEPTH_LIMIT = cpsdp_pkg::DEPTH_LIMIT_DEF,
    parameter int unsigned VALUE_BITS  = cpsdp_pkg::VALUE_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_count,
    input  logic             take,
    input  cpsdp_pkg::in_t   item,
    output logic             res_valid,
    output cpsdp_pkg::out_t  res
);

    localparam int unsigned REM_W = $clog2(MAX_DIGITS + 1);
    localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [VALUE_BITS-1:0] VMASK  = '1;
    localparam logic [VALUE_BITS-1:0] FW_SAT = VALUE_BITS'(8'd255);

    typedef enum logic [1:0] {PH_IDLE, PH_LENGTH, PH_VALUE} phase_t;
    typedef enum logic [1:0] {CMP_EQ, CMP_LT, CMP_GT} cmp_t;

    logic [7:0] max_chars [MAX_DIGITS];

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_max
        assign max_chars[g] = cpsdp_pkg::max_digit_char(VALUE_BITS, MAX_DIGITS - 1 - g);
    end

    logic [7:0]            initial_count_reg, initial_count_next;
    phase_t                phase_reg, phase_next;
    logic [REM_W-1:0]      remaining_reg, remaining_next;
    logic [7:0]            field_width_reg, field_width_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    cmp_t                  cmp_reg, cmp_next;
    logic                  nondigit_reg, nondigit_next;
    logic                  sign_reg, sign_next;
    logic [7:0]            depth_reg, depth_next;

    logic [7:0]            ch;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [REM_W-1:0]      pos;
    logic [REM_W-1:0]      rem_dec;
    logic [7:0]            max_c;
    cmp_t                  cmp_char;
    cmp_t                  cmp_upd;
    logic [VALUE_BITS-1:0] acc_x10;
    logic [VALUE_BITS-1:0] acc_upd;
    logic                  nondigit_upd;
    logic                  len_done;
    logic [VALUE_BITS-1:0] len_acc;
    logic                  emit;
    cpsdp_pkg::status_t    st;
    logic                  neg;
    logic [VALUE_BITS-1:0] val;
    logic [7:0]            restart_count;

    assign ch       = item.char_in;
    assign is_digit = (ch >= cpsdp_pkg::CH_ZERO) && (ch <= cpsdp_pkg::CH_NINE);
    assign digit    = 4'(ch - cpsdp_pkg::CH_ZERO);
    assign pos      = field_width_reg[REM_W-1:0] - remaining_reg;
    assign rem_dec  = (remaining_reg != '0) ? remaining_reg - REM_W'(1) : '0;
    assign max_c    = (phase_reg == PH_IDLE) ? max_chars[0] : max_chars[pos[IDX_W-1:0]];

    always_comb begin
        if (ch > max_c) begin
            cmp_char = CMP_GT;
        end else if (ch < max_c) begin
            cmp_char = CMP_LT;
        end else begin
            cmp_char = CMP_EQ;
        end
    end

    assign cmp_upd      = (cmp_reg == CMP_EQ) ? cmp_char : cmp_reg;
    assign acc_x10      = {acc_reg[VALUE_BITS-4:0], 3'b000} + {acc_reg[VALUE_BITS-2:0], 1'b0};
    assign acc_upd      = is_digit ? acc_x10 + VALUE_BITS'(digit) : acc_reg;
    assign nondigit_upd = nondigit_reg | ~is_digit;

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        field_width_next = field_width_reg;
        acc_next       = acc_reg;
        cmp_next       = cmp_reg;
        nondigit_next  = nondigit_reg;
        sign_next      = sign_reg;
        depth_next     = depth_reg;
        initial_count_next = initial_count_reg;
        emit     = 1'b0;
        st       = cpsdp_pkg::ST_OK;
        neg      = 1'b0;
        val      = '0;
        len_done = 1'b0;
        len_acc  = '0;

        case (phase_reg)
            PH_LENGTH, PH_VALUE: begin
                if (item.kind != cpsdp_pkg::KIND_CHAR) begin
                    emit = 1'b1;
                    st   = cpsdp_pkg::ST_EOD;
                end else if (rem_dec != '0) begin
                    remaining_next = rem_dec;
                    acc_next       = acc_upd;
                    cmp_next       = cmp_upd;
                    nondigit_next  = nondigit_upd;
                end else if (field_width_reg == 8'(MAX_DIGITS) && cmp_upd == CMP_GT) begin
                    emit = 1'b1;
                    st   = cpsdp_pkg::ST_OVERFLOW;
                    neg  = (phase_reg == PH_VALUE) ? sign_reg : 1'b0;
                    val  = VMASK;
                end else if (nondigit_upd) begin
                    emit = 1'b1;
                    st   = cpsdp_pkg::ST_NONDIGIT;
                end else if (phase_reg == PH_VALUE) begin
                    emit = 1'b1;
                    st   = cpsdp_pkg::ST_OK;
                    neg  = sign_reg;
                    val  = acc_upd;
                end else begin
                    len_done = 1'b1;
                    len_acc  = acc_upd;
                end
            end
            default: begin
                if (item.kind == cpsdp_pkg::KIND_EOF) begin
                    emit = 1'b1;
                    st   = cpsdp_pkg::ST_EOF;
                end else if (item.kind != cpsdp_pkg::KIND_CHAR) begin
                    emit = 1'b1;
                    st   = cpsdp_pkg::ST_EOD;
                end else if (ch == cpsdp_pkg::CH_MINUS || ch == cpsdp_pkg::CH_PLUS) begin
                    if (field_width_reg > 8'(MAX_DIGITS)) begin
                        emit = 1'b1;
                        st   = cpsdp_pkg::ST_OVERFLOW;
                        val  = VMASK;
                    end else begin
                        sign_next      = (ch == cpsdp_pkg::CH_MINUS);
                        phase_next     = PH_VALUE;
                        remaining_next = field_width_reg[REM_W-1:0];
                        acc_next       = '0;
                        cmp_next       = CMP_EQ;
                        nondigit_next  = 1'b0;
                    end
                end else if (ch == cpsdp_pkg::CH_ZERO) begin
                    emit = 1'b1;
                    st   = cpsdp_pkg::ST_LEADZERO;
                end else if (!is_digit) begin
                    emit = 1'b1;
                    st   = cpsdp_pkg::ST_NONDIGIT;
                end else if (field_width_reg > 8'(MAX_DIGITS)) begin
                    emit = 1'b1;
                    st   = cpsdp_pkg::ST_OVERFLOW;
                    val  = VMASK;
                end else if (field_width_reg > 8'd1) begin
                    phase_next     = PH_LENGTH;
                    remaining_next = REM_W'(field_width_reg - 8'd1);
                    acc_next       = VALUE_BITS'(digit);
                    cmp_next       = cmp_char;
                    nondigit_next  = 1'b0;
                end else begin
                    len_done = 1'b1;
                    len_acc  = VALUE_BITS'(digit);
                end
            end
        endcase

        // a length field completed: open the next field or hit the depth limit
        if (len_done) begin
            if ({1'b0, depth_reg} + 9'd2 > 9'(DEPTH_LIMIT)) begin
                emit = 1'b1;
                st   = cpsdp_pkg::ST_PROTO;
            end else begin
                depth_next       = depth_reg + 8'd1;
                field_width_next = (len_acc > FW_SAT) ? 8'd255 : len_acc[7:0];
                phase_next       = PH_IDLE;
                remaining_next   = '0;
                acc_next         = '0;
                cmp_next         = CMP_EQ;
                nondigit_next    = 1'b0;
            end
        end

        if (!take) begin
            emit = 1'b0;
        end

        restart_count = initial_count_reg;
        if (cfg_we) begin
            initial_count_next = cfg_count;
            restart_count      = cfg_count;
        end

        if (cfg_we || emit) begin
            phase_next       = PH_IDLE;
            remaining_next   = '0;
            field_width_next = (restart_count == 8'd0) ? 8'd1 : restart_count;
            acc_next         = '0;
            cmp_next         = CMP_EQ;
            nondigit_next    = 1'b0;
            sign_next        = 1'b0;
            depth_next       = '0;
        end
    end

    assign res_valid    = emit;
    assign res.status   = st;
    assign res.negative = neg;
    assign res.value    = 64'(val);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_count_reg <= 8'd1;
            phase_reg         <= PH_IDLE;
            remaining_reg     <= '0;
            field_width_reg   <= 8'd1;
            acc_reg           <= '0;
            cmp_reg           <= CMP_EQ;
            nondigit_reg      <= 1'b0;
            sign_reg          <= 1'b0;
            depth_reg         <= '0;
        end else if (take || cfg_we) begin
            initial_count_reg <= initial_count_next;
            phase_reg         <= phase_next;
            remaining_reg     <= remaining_next;
            field_width_reg   <= field_width_next;
            acc_reg           <= acc_next;
            cmp_reg           <= cmp_next;
            nondigit_reg      <= nondigit_next;
            sign_reg          <= sign_next;
            depth_reg         <= depth_next;
        end
    end

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        remaining_reg <= REM_W'(MAX_DIGITS))
        else $error("remaining count beyond field limit");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, depth_reg} < 9'(DEPTH_LIMIT))
        else $error("nesting depth reached limit without protocol result");

    a_idle_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> remaining_reg == '0)
        else $error("idle phase with characters pending");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> phase_reg == PH_IDLE && depth_reg == '0 && field_width_reg != 8'd0)
        else $error("config write did not restart the decode");

    a_result_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !cfg_we |=> phase_reg == PH_IDLE && depth_reg == '0)
        else $error("result beat without restart");

endmodule

// ===== sv/count_prefixed_signed_decimal_parser.sv =====
// top level: input register, decode core, result register
// Decodes a signed integer from a byte stream in which nested decimal length fields
// give the width of each following field, and a '+' or '-' opens the value field.
// Each decode ends in exactly one result beat carrying a status, the sign and the
// magnitude. The block accepts one input beat per cycle and sustains that rate while
// m_ready stays high; a beat that ends a decode passes the input register and then
// the result register before its result shows. The step logic does one times-ten
// add on the accumulator plus a byte compare against the largest representable
// value for each beat. Writing initial_count on the cfg port restarts the decode at
// the first field; write it only while no input beat is held.
module count_prefixed_signed_decimal_parser #(
    parameter int unsigned MAX_DIGITS  = cpsdp_pkg::MAX_DIGITS_DEF,
    parameter int unsigned DEPTH_LIMIT = cpsdp_pkg::DEPTH_LIMIT_DEF,
    parameter int unsigned VALUE_BITS  = cpsdp_pkg::VALUE_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  cpsdp_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output cpsdp_pkg::out_t m_data
);

    logic            in_valid_reg;
    cpsdp_pkg::in_t  in_data_reg;
    logic            m_valid_reg;
    cpsdp_pkg::out_t m_data_reg;
    logic            out_space;
    logic            take;
    logic            res_valid;
    cpsdp_pkg::out_t res;

    assign cfg_ready = 1'b1;
    assign out_space = !m_valid_reg || m_ready;
    assign take      = in_valid_reg && out_space;
    assign s_ready   = !in_valid_reg || take;

    cpsdp_core #(
        .MAX_DIGITS  (MAX_DIGITS),
        .DEPTH_LIMIT (DEPTH_LIMIT),
        .VALUE_BITS  (VALUE_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_count (cfg_data),
        .take      (take),
        .item      (in_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_space) begin
                m_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (out_space && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
